/* src/assert_macros.svh */
// Assertion helper macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// Check an implication in the next cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

/* src/qse_pkg.sv */
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types and constants of the quicksort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package qse_pkg;
	localparam int MaxItems = 64;
	localparam int IdxW = $clog2(MaxItems);
	localparam int CntW = IdxW + 1;
	localparam int QDepth = 4;
	localparam int QIdxW = $clog2(QDepth);

	typedef struct packed {
		logic signed [31:0] value;
		logic last_item;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic end_of_batch;
		logic overflow;
	} out_item_t;

	// Command from front to back.
	typedef struct packed {
		logic [31:0] value;
		logic store;
		logic last;
		logic drop;
	} cmd_t;
endpackage

/* src/qse_ram.sv */
// ----------------------------------------------------------------------------
// qse_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module qse_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/qse_front.sv */
// ----------------------------------------------------------------------------
// qse_front
// Accepts items, flags drops and queues commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module qse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qse_pkg::in_item_t in_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output qse_pkg::cmd_t     cmd
);
	import qse_pkg::*;

	logic [CntW-1:0]  cnt_q;
	cmd_t             q_mem [QDepth];
	logic [QIdxW-1:0] wp_q, rp_q;
	logic [QIdxW:0]   fill_q;
	logic             push, pop, full_store;
	cmd_t             nc;

	assign full_store = cnt_q == CntW'(MaxItems);
	assign in_ready = fill_q != (QIdxW+1)'(QDepth);
	assign push = in_valid && in_ready;
	assign cmd_valid = fill_q != '0;
	assign pop = cmd_valid && cmd_ready;
	assign cmd = q_mem[rp_q];

	always_comb begin
		nc.value = in_data.value ^ 32'h8000_0000;
		nc.store = !full_store;
		nc.drop = full_store;
		nc.last = in_data.last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				q_mem[wp_q] <= nc;
				wp_q <= wp_q + 1'b1;
				if (in_data.last_item) begin
					cnt_q <= '0;
				end else if (!full_store) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			fill_q <= fill_q + (QIdxW+1)'(push) - (QIdxW+1)'(pop);
		end
	end
endmodule

/* src/qse_back.sv */
// ----------------------------------------------------------------------------
// qse_back
// Stores elements, runs the stack-driven hole partition and emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module qse_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  qse_pkg::cmd_t      cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output qse_pkg::out_item_t out_data
);
	import qse_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SRD, ST_POP, ST_PIV, ST_RRD, ST_RCHK, ST_LRD, ST_LCHK, ST_FIN,
		ST_ORD, ST_OWAIT, ST_OUT
	} state_t;

	state_t            state_q;
	logic [CntW-1:0]   cnt_q, sp_q, oi_q;
	logic              drop_q;
	logic [IdxW-1:0]   lo_q, hi_q, left_q, right_q;
	logic [31:0]       pv_q;
	logic              we, swe;
	logic [IdxW-1:0]   waddr, raddr;
	logic [31:0]       wdata, rdata;
	logic [2*IdxW-1:0] swdata, srdata;
	logic [IdxW-1:0]   swaddr;
	logic              push2_q;
	logic [2*IdxW-1:0] pend_q;

	qse_ram #(.Width(32), .Depth(MaxItems)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);
	qse_ram #(.Width(2*IdxW), .Depth(MaxItems)) u_stack (
		.clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
		.raddr(IdxW'(sp_q - 1'b1)), .rdata(srdata)
	);

	assign cmd_ready = state_q == ST_IDLE;

	always_comb begin
		we = 1'b0;
		waddr = left_q;
		wdata = rdata;
		raddr = right_q;
		swe = 1'b0;
		swaddr = sp_q[IdxW-1:0];
		swdata = pend_q;
		case (state_q)
			ST_IDLE: begin
				we = cmd_valid && cmd.store;
				waddr = cnt_q[IdxW-1:0];
				wdata = cmd.value;
				swe = 1'b1;
				swaddr = '0;
				swdata = {IdxW'(0), IdxW'(cnt_q - (cmd.store ? 1'b0 : 1'b1))};
			end
			ST_POP: raddr = srdata[2*IdxW-1:IdxW];
			ST_RRD: raddr = right_q;
			ST_RCHK: begin
				we = left_q < right_q && rdata < pv_q;
				waddr = left_q;
			end
			ST_LRD: raddr = left_q;
			ST_LCHK: begin
				we = left_q < right_q && rdata > pv_q;
				waddr = right_q;
			end
			ST_FIN: begin
				we = 1'b1;
				waddr = left_q;
				wdata = pv_q;
				swe = push2_q;
			end
			ST_ORD: raddr = oi_q[IdxW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			sp_q <= '0;
			oi_q <= '0;
			drop_q <= 1'b0;
			out_valid <= 1'b0;
			push2_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd_valid) begin
					if (cmd.store) cnt_q <= cnt_q + 1'b1;
					if (cmd.drop) drop_q <= 1'b1;
					if (cmd.last) begin
						oi_q <= '0;
						if ((cmd.store ? cnt_q + 1'b1 : cnt_q) >= CntW'(2)) begin
							sp_q <= CntW'(1);
							state_q <= ST_SRD;
						end else begin
							state_q <= ST_ORD;
						end
					end
				end
				ST_SRD: state_q <= ST_POP;
				ST_POP: begin
					lo_q <= srdata[2*IdxW-1:IdxW];
					left_q <= srdata[2*IdxW-1:IdxW];
					hi_q <= srdata[IdxW-1:0];
					right_q <= srdata[IdxW-1:0];
					sp_q <= sp_q - 1'b1;
					state_q <= ST_PIV;
				end
				ST_PIV: begin
					pv_q <= rdata;
					state_q <= ST_RRD;
				end
				ST_RRD: state_q <= ST_RCHK;
				ST_RCHK: begin
					if (!(left_q < right_q)) begin
						state_q <= ST_FIN;
					end else if (rdata >= pv_q) begin
						right_q <= right_q - 1'b1;
						state_q <= (right_q - 1'b1 > left_q) ? ST_RRD : ST_FIN;
					end else begin
						left_q <= left_q + 1'b1;
						state_q <= (left_q + 1'b1 < right_q) ? ST_LRD : ST_FIN;
					end
				end
				ST_LRD: state_q <= ST_LCHK;
				ST_LCHK: begin
					if (!(left_q < right_q)) begin
						state_q <= ST_FIN;
					end else if (rdata <= pv_q) begin
						left_q <= left_q + 1'b1;
						state_q <= (left_q + 1'b1 < right_q) ? ST_LRD : ST_FIN;
					end else begin
						right_q <= right_q - 1'b1;
						state_q <= (right_q - 1'b1 > left_q) ? ST_RRD : ST_FIN;
					end
				end
				ST_FIN: begin
					// Stage each pending partition, then push it.
					if (!push2_q) begin
						if ((CntW'(left_q)) > CntW'(lo_q) + 1'b1) begin
							push2_q <= 1'b1;
							pend_q <= {lo_q, left_q - 1'b1};
						end else if (CntW'(left_q) + 1'b1 < CntW'(hi_q)) begin
							push2_q <= 1'b1;
							pend_q <= {left_q + 1'b1, hi_q};
						end else begin
							state_q <= sp_q != '0 ? ST_SRD : ST_ORD;
						end
					end else begin
						sp_q <= sp_q + 1'b1;
						if (pend_q[2*IdxW-1:IdxW] == lo_q &&
						    CntW'(left_q) + 1'b1 < CntW'(hi_q)) begin
							pend_q <= {left_q + 1'b1, hi_q};
						end else begin
							push2_q <= 1'b0;
							state_q <= ST_SRD;
						end
					end
				end
				ST_ORD: state_q <= ST_OWAIT;
				ST_OWAIT: begin
					if (oi_q >= cnt_q) begin
						cnt_q <= '0;
						drop_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						out_data.sorted_value <= rdata ^ 32'h8000_0000;
						out_data.end_of_batch <= oi_q + 1'b1 == cnt_q;
						out_data.overflow <= drop_q;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					oi_q <= oi_q + 1'b1;
					state_q <= ST_ORD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* src/quicksort_engine_core.sv */
// Quicksort engine. Items load one per cycle into a 64-entry store through a
// four-entry queue while the back end idles; the item marked last starts an
// in-place quicksort with first-element pivots and a pending-partition stack,
// after which the values leave in ascending order through the single store
// read port. The sort is bound by that read port as well.
// ----------------------------------------------------------------------------
// quicksort_engine_core
// Top level: front end, command queue and sorting back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module quicksort_engine_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qse_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output qse_pkg::out_item_t out_data
);
	import qse_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	qse_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);
	qse_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

/* src/qse_checker.sv */
// ----------------------------------------------------------------------------
// qse_checker
// Port-level checks of the quicksort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input qse_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input qse_pkg::out_item_t out_data
);
	import qse_pkg::*;

	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`CHK_NEXT(a_ovf_steady, clk, arst_n, out_valid && out_ready && !out_data.end_of_batch,
		!out_valid || out_data.overflow == $past(out_data.overflow))
	`CHK_IMPLY(a_no_x, clk, arst_n, 1'b1, !$isunknown({out_valid, in_ready}))
	`CHK_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_data))
endmodule

bind quicksort_engine_core qse_checker u_chk (.*);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of quicksort_engine_core: loads batches of signed values, predicts
// the ascending output with an in-bench sorter and checks every result item,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
	import qse_pkg::*;

	localparam int WatchLimit = 40000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	out_item_t expected_sorted[$];
	logic signed [31:0] batch_values[$];
	logic batch_dropped;
	int errors;
	int idle_cycles;
	bit stall_enable;

	quicksort_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sort the batch and queue the results it produces.
	function automatic void predict_batch();
		logic signed [31:0] vals[$];
		logic signed [31:0] t;
		out_item_t r;
		vals = batch_values;
		for (int i = 1; i < vals.size(); i++) begin
			t = vals[i];
			for (int j = i - 1; j >= 0 && vals[j] > t; j--) begin
				vals[j + 1] = vals[j];
				vals[j] = t;
			end
		end
		foreach (vals[i]) begin
			r.sorted_value = vals[i];
			r.end_of_batch = (i == vals.size() - 1);
			r.overflow = batch_dropped;
			expected_sorted.push_back(r);
		end
		batch_values.delete();
		batch_dropped = 1'b0;
	endfunction

	task automatic send_item(input logic signed [31:0] v, input logic last);
		int g;
		g = gap_length();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.value <= v;
		in_data.last_item <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (batch_values.size() < MaxItems) batch_values.push_back(v);
		else batch_dropped = 1'b1;
		if (last) predict_batch();
	endtask

	task automatic send_batch(input int n, input int mode);
		logic signed [31:0] v;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: v = $urandom;
				1: v = $signed($urandom_range(0, 7)) - 4;
				2: v = i;
				default: v = n - i;
			endcase
			send_item(v, i == n - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_sorted.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_extremes();
		send_item(32'sh7fffffff, 1'b0);
		send_item(32'sh80000000, 1'b0);
		send_item(0, 1'b0);
		send_item(-1, 1'b0);
		send_item(1, 1'b1);
		send_item(32'sh80000000, 1'b1);
		send_item(5, 1'b0);
		send_item(5, 1'b1);
		drain();
	endtask

	task automatic test_orders();
		send_batch(6, 2);
		send_batch(6, 3);
		send_batch(5, 1);
		drain();
	endtask

	task automatic test_overflow();
		send_batch(MaxItems, 0);
		send_batch(MaxItems + 3, 0);
		drain();
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 115) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MaxItems)
				: $urandom_range(1, 12);
			stall_enable = ($urandom_range(0, 3) != 0);
			send_batch(n, $urandom_range(0, 3));
			sent += n;
		end
		stall_enable = 1'b1;
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_sorted.size() == 0) begin
				$error("unexpected sorted item %0d", out_data.sorted_value);
				errors++;
			end else begin
				out_item_t e;
				e = expected_sorted.pop_front();
				if (out_data.sorted_value !== e.sorted_value) begin
					$error("sorted_value exp %0d got %0d", e.sorted_value,
						out_data.sorted_value);
					errors++;
				end
				if (out_data.end_of_batch !== e.end_of_batch) begin
					$error("end_of_batch exp %0b got %0b", e.end_of_batch,
						out_data.end_of_batch);
					errors++;
				end
				if (out_data.overflow !== e.overflow) begin
					$error("overflow exp %0b got %0b", e.overflow, out_data.overflow);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!stall_enable) out_ready <= 1'b1;
		else case ($urandom_range(0, 19))
			0: out_ready <= 1'b0;
			1, 2, 3: out_ready <= ~out_ready;
			default: out_ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("quicksort_engine_core: mismatch");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		batch_dropped = 1'b0;
		stall_enable = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_orders();
		test_overflow();
		test_random();
		drain();
		if (errors == 0) $display("quicksort_engine_core: match");
		else $display("quicksort_engine_core: mismatch");
		$finish;
	end
endmodule
